// ===== src/kwf_pkg.sv =====
// Shared types and constants of the Kuwahara window filter.
// No dependencies; every other file of the block but kwf_ram imports this package.
package kwf_pkg;

  localparam int COL_BITS       = 11;
  localparam int ROW_BITS       = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [COL_BITS-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [ROW_BITS-1:0] HEIGHT_RESET = 16'd1024;

  // floor(x / 3) = (x * DIV3_K) >> DIV3_SHIFT for any 32-bit x
  localparam logic [31:0] DIV3_K     = 32'hAAAAAAAB;
  localparam int          DIV3_SHIFT = 33;

  // quadrant neighbor offsets: top-left, top-right, bottom-left, bottom-right
  localparam logic signed [2:0] QUAD_DX [4][4] = '{
    '{-3'sd2, -3'sd1, -3'sd2, -3'sd1},
    '{ 3'sd1,  3'sd2,  3'sd1,  3'sd2},
    '{-3'sd2, -3'sd1, -3'sd2, -3'sd1},
    '{ 3'sd1,  3'sd2,  3'sd1,  3'sd2}
  };
  localparam logic signed [2:0] QUAD_DY [4][4] = '{
    '{-3'sd2, -3'sd2, -3'sd1, -3'sd1},
    '{-3'sd2, -3'sd2, -3'sd1, -3'sd1},
    '{ 3'sd1,  3'sd1,  3'sd2,  3'sd2},
    '{ 3'sd1,  3'sd1,  3'sd2,  3'sd2}
  };

  typedef struct packed {
    logic [COL_BITS-1:0] w;
    logic [ROW_BITS-1:0] h;
  } kwf_geom_t;

  typedef struct packed {
    logic [COL_BITS-1:0] col;
    logic [ROW_BITS-1:0] row;
    logic                frame_end;
  } kwf_job_t;

endpackage

// ===== src/kuwahara_window_filter_top.sv =====
// Top level of the Kuwahara 5x5 window filter for RGB raster streams.
// Depends on kwf_pkg, kwf_ram, kwf_jobq, kwf_front and kwf_back.
//
// Usage:
//  - Input channel (in_valid/in_ready) takes one word per accepted item: a
//    pixel, or a drain tick that flushes the tail of the frame once all
//    image_width*image_height pixels have arrived. Mid-frame drain ticks
//    are taken and dropped.
//  - Output channel (out_valid/out_ready) gives the filtered pixel in raster
//    order; frame_end marks the last pixel of the frame.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//    image_width (index 0) and image_height (index 1); a write to either
//    register restarts the frame. Write only while the block is idle.
//  - Outputs trail inputs by 2*width+2 items. The back end handles each
//    output with the shared divider and the bit-serial square root run for
//    each channel of each quadrant.
//  - The front keeps accepting pixels into a two-entry job queue while the
//    back works or the receiver stalls; when the queue is full or a register
//    write is offered, in_ready drops. After the frame end job the front
//    holds until the back is done.
//  - Reset clears positions and restores both registers to 1024. The line
//    store needs no clearing: only pixels of the current frame are read.
module kuwahara_window_filter_top import kwf_pkg::*; #(
  parameter int MAX_WIDTH    = 1024,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CHANNEL_BITS-1:0]   pixel_red,
  input  logic [CHANNEL_BITS-1:0]   pixel_green,
  input  logic [CHANNEL_BITS-1:0]   pixel_blue,
  input  logic                      drain_tick,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CHANNEL_BITS-1:0]   out_red,
  output logic [CHANNEL_BITS-1:0]   out_green,
  output logic [CHANNEL_BITS-1:0]   out_blue,
  output logic                      frame_end
);

  // eight row slots of the line store, addressed by row and column
  localparam int AW        = $clog2(MAX_WIDTH) + 3;
  localparam int RAM_DEPTH = 8 * (1 << $clog2(MAX_WIDTH));
  localparam int PW        = 3 * CHANNEL_BITS;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [PW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [PW-1:0] ram_rdata;
  kwf_geom_t     geom;
  logic          push;
  kwf_job_t      push_job;
  logic          pop;
  kwf_job_t      head;
  logic          q_full;
  logic          q_empty;
  logic          back_idle;

  kwf_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_red   (pixel_red),
    .pixel_green (pixel_green),
    .pixel_blue  (pixel_blue),
    .drain_tick  (drain_tick),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .geom        (geom),
    .push        (push),
    .push_job    (push_job),
    .q_full      (q_full),
    .q_empty     (q_empty),
    .back_idle   (back_idle)
  );

  kwf_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  kwf_ram #(
    .WIDTH (PW),
    .DEPTH (RAM_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kwf_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .idle      (back_idle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .frame_end (frame_end)
  );

endmodule

// ===== src/kwf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module kwf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/kwf_jobq.sv =====
// Two-entry queue of output jobs between front and back.
// Depends on kwf_pkg for the job type.
module kwf_jobq import kwf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  kwf_job_t push_job,
  input  logic     pop,
  output kwf_job_t head,
  output logic     full,
  output logic     empty
);

  kwf_job_t   entry [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign head  = entry[rp];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= push_job;
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== src/kwf_front.sv =====
// Front end: configuration registers, input positions, line store writes and
// emission of output jobs. Depends on kwf_pkg.
module kwf_front import kwf_pkg::*; #(
  parameter int MAX_WIDTH    = 1024,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [CHANNEL_BITS-1:0]      pixel_red,
  input  logic [CHANNEL_BITS-1:0]      pixel_green,
  input  logic [CHANNEL_BITS-1:0]      pixel_blue,
  input  logic                         drain_tick,
  output logic                         ram_we,
  output logic [$clog2(MAX_WIDTH)+2:0] ram_waddr,
  output logic [3*CHANNEL_BITS-1:0]    ram_wdata,
  output kwf_geom_t                    geom,
  output logic                         push,
  output kwf_job_t                     push_job,
  input  logic                         q_full,
  input  logic                         q_empty,
  input  logic                         back_idle
);

  localparam int CA = $clog2(MAX_WIDTH);
  localparam int LW = COL_BITS + 2;

  logic [COL_BITS-1:0] width_reg;
  logic [ROW_BITS-1:0] height_reg;
  logic [COL_BITS-1:0] in_col;
  logic [ROW_BITS-1:0] in_row;
  logic [COL_BITS-1:0] out_col;
  logic [ROW_BITS-1:0] out_row;
  logic [LW-1:0]       lead;
  logic                hold;

  logic          cfg_hit;
  logic          acc;
  logic          in_done;
  logic          pix_wr;
  logic          emit;
  logic          fe;
  logic [LW-1:0] thr;

  always_comb begin
    if (width_reg < 11'd2) begin
      geom.w = 11'd2;
    end else if (32'(width_reg) > MAX_WIDTH) begin
      geom.w = COL_BITS'(MAX_WIDTH);
    end else begin
      geom.w = width_reg;
    end
    geom.h = (height_reg < 16'd2) ? 16'd2 : height_reg;
  end

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT});
  // hold input off while a register write is offered
  assign in_ready  = !q_full && !hold && !cfg_valid;
  assign acc       = in_valid && in_ready;
  assign in_done   = (in_row == geom.h);
  assign pix_wr    = acc && !in_done && !drain_tick;
  assign thr       = LW'({geom.w, 1'b0}) + LW'(2);
  assign emit      = acc && (in_done || (pix_wr && lead >= thr));
  assign fe        = (out_row == geom.h - 16'd1) && (out_col == geom.w - 11'd1);

  assign push               = emit;
  assign push_job.col       = out_col;
  assign push_job.row       = out_row;
  assign push_job.frame_end = fe;

  assign ram_we    = pix_wr;
  assign ram_waddr = {in_row[2:0], CA'(in_col)};
  assign ram_wdata = {pixel_blue, pixel_green, pixel_red};

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
      in_col     <= '0;
      in_row     <= '0;
      out_col    <= '0;
      out_row    <= '0;
      lead       <= '0;
      hold       <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_IMAGE_WIDTH) width_reg <= cfg_data[COL_BITS-1:0];
      if (cfg_index == REG_IMAGE_HEIGHT) height_reg <= cfg_data;
      if (cfg_hit) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
        lead    <= '0;
      end
    end else begin
      if (pix_wr) begin
        if ((COL_BITS+1)'(in_col) + 12'd1 >= (COL_BITS+1)'(geom.w)) begin
          in_col <= '0;
          in_row <= in_row + 16'd1;
        end else begin
          in_col <= in_col + 11'd1;
        end
        if (!emit) lead <= lead + LW'(1);
      end
      if (emit) begin
        if (fe) begin
          // restart the frame; wait for the back end before the next one
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
          lead    <= '0;
          hold    <= 1'b1;
        end else if (out_col + 11'd1 >= geom.w) begin
          out_col <= '0;
          out_row <= out_row + 16'd1;
        end else begin
          out_col <= out_col + 11'd1;
        end
      end
      if (hold && q_empty && back_idle) hold <= 1'b0;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("job pushed into a full queue");
  a_fe_hold: assert property (@(posedge clk) disable iff (rst)
    (push && push_job.frame_end) |=> hold)
    else $error("frame end did not hold the front");
  a_lead: assert property (@(posedge clk) disable iff (rst) lead <= thr)
    else $error("input lead beyond window span");

endmodule

// ===== src/kwf_back.sv =====
// Back end: reads the quadrant neighbors of each job, forms mean and
// deviation per channel with a shared divider and a bit-serial square root,
// and presents the winning mean. Depends on kwf_pkg.
module kwf_back import kwf_pkg::*; #(
  parameter int MAX_WIDTH    = 1024,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  kwf_geom_t                    geom,
  input  logic                         q_empty,
  input  kwf_job_t                     head,
  output logic                         pop,
  output logic                         ram_re,
  output logic [$clog2(MAX_WIDTH)+2:0] ram_raddr,
  input  logic [3*CHANNEL_BITS-1:0]    ram_rdata,
  output logic                         idle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [CHANNEL_BITS-1:0]      out_red,
  output logic [CHANNEL_BITS-1:0]      out_green,
  output logic [CHANNEL_BITS-1:0]      out_blue,
  output logic                         frame_end
);

  localparam int CB   = CHANNEL_BITS;
  localparam int CA   = $clog2(MAX_WIDTH);
  localparam int SB   = CB + 2;
  localparam int QB   = 2 * CB + 2;
  localparam int NW   = 2 * CB + 6;
  localparam int SW   = CB + 2;
  localparam int VW   = 2 * SW;
  localparam int DW   = SW + 2;
  localparam int CNTW = $clog2(SW + 1);
  localparam int XW   = COL_BITS + 2;
  localparam int YW   = ROW_BITS + 2;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_RD   = 3'd1;
  localparam logic [2:0] B_ACC  = 3'd2;
  localparam logic [2:0] B_DM   = 3'd3;
  localparam logic [2:0] B_DV   = 3'd4;
  localparam logic [2:0] B_SQ0  = 3'd5;
  localparam logic [2:0] B_SQ   = 3'd6;
  localparam logic [2:0] B_OUT  = 3'd7;

  logic [2:0]      state;
  kwf_job_t        job;
  logic [1:0]      q;
  logic [1:0]      k;
  logic [1:0]      c;
  logic            pend;
  logic [2:0]      n;
  logic [SB-1:0]   sum  [3];
  logic [QB-1:0]   sq   [3];
  logic [CB+1:0]   m4;
  logic [NW-1:0]   v16;
  logic [VW-1:0]   rad;
  logic [DW-1:0]   rem;
  logic [SW-1:0]   root;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   dev;
  logic [CB-1:0]   mean [3];
  logic            best_has;
  logic [DW-1:0]   best_dev;
  logic [CB-1:0]   best [3];

  logic signed [XW-1:0] nx;
  logic signed [YW-1:0] ny;
  logic                 nb_valid;
  logic [NW-1:0]        div_x;
  logic [NW-1:0]        div_q;
  logic [63:0]          prod;
  logic [VW-1:0]        msq;
  logic [CB+2:0]        mean_r;
  logic [DW-1:0]        rem_sh;
  logic [DW-1:0]        trial;
  logic                 ge;
  logic [SW-1:0]        root_n;
  logic [DW-1:0]        dev_tot;
  logic [CB-1:0]        ch    [3];
  logic [2*CB-1:0]      ch_sq [3];

  always_comb begin
    nx = $signed({2'b00, job.col}) + XW'(QUAD_DX[q][k]);
    ny = $signed({2'b00, job.row}) + YW'(QUAD_DY[q][k]);
    nb_valid = !nx[XW-1] && (nx < $signed({2'b00, geom.w})) &&
               !ny[YW-1] && (ny < $signed({2'b00, geom.h}));
  end

  assign ram_re    = (state == B_RD) && nb_valid;
  assign ram_raddr = {ny[2:0], CA'(nx[XW-2:0])};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ch[i]    = ram_rdata[i*CB +: CB];
      ch_sq[i] = ch[i] * ch[i];
    end
  end

  // shared divide by the pixel count
  always_comb begin
    div_x = (state == B_DV) ? {sq[c], 4'b0000} : NW'({sum[c], 2'b00});
    prod  = {32'd0, 32'(div_x)} * {32'd0, DIV3_K};
    case (n)
      3'd1:    div_q = div_x;
      3'd2:    div_q = div_x >> 1;
      3'd3:    div_q = NW'(prod[63:DIV3_SHIFT]);
      3'd4:    div_q = div_x >> 2;
      default: div_q = '0;
    endcase
  end

  assign msq    = m4 * m4;
  assign mean_r = (CB+3)'(m4) + (CB+3)'(2);

  // one digit of the square root per cycle
  always_comb begin
    rem_sh  = {rem[DW-3:0], rad[VW-1:VW-2]};
    trial   = {root, 2'b01};
    ge      = (rem_sh >= trial);
    root_n  = {root[SW-2:0], ge};
    dev_tot = dev + DW'(root_n);
  end

  assign pop       = (state == B_IDLE) && !q_empty;
  assign idle      = (state == B_IDLE);
  assign out_valid = (state == B_OUT);
  assign out_red   = best[0];
  assign out_green = best[1];
  assign out_blue  = best[2];
  assign frame_end = job.frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      pend  <= 1'b0;
      n     <= 3'd0;
    end else begin
      if ((state == B_RD || state == B_ACC) && pend) begin
        n <= n + 3'd1;
        for (int i = 0; i < 3; i++) begin
          sum[i] <= sum[i] + SB'(ch[i]);
          sq[i]  <= sq[i] + QB'(ch_sq[i]);
        end
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            job      <= head;
            q        <= 2'd0;
            k        <= 2'd0;
            n        <= 3'd0;
            dev      <= '0;
            best_has <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              sum[i]  <= '0;
              sq[i]   <= '0;
              best[i] <= '0;
            end
            state <= B_RD;
          end
        end
        B_RD: begin
          pend <= nb_valid;
          k    <= k + 2'd1;
          if (k == 2'd3) state <= B_ACC;
        end
        B_ACC: begin
          pend <= 1'b0;
          c    <= 2'd0;
          if (n == 3'd0 && !pend) begin
            // skip an empty quadrant
            if (q == 2'd3) begin
              state <= B_OUT;
            end else begin
              q <= q + 2'd1;
              state <= B_RD;
            end
          end else begin
            state <= B_DM;
          end
        end
        B_DM: begin
          m4    <= (CB+2)'(div_q);
          state <= B_DV;
        end
        B_DV: begin
          v16   <= div_q;
          state <= B_SQ0;
        end
        B_SQ0: begin
          rad     <= (v16 > NW'(msq)) ? VW'(v16 - NW'(msq)) : '0;
          rem     <= '0;
          root    <= '0;
          cnt     <= CNTW'(SW);
          mean[c] <= mean_r[CB+1:2];
          state   <= B_SQ;
        end
        B_SQ: begin
          rem  <= ge ? (rem_sh - trial) : rem_sh;
          root <= root_n;
          rad  <= rad << 2;
          cnt  <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) begin
            if (c == 2'd2) begin
              if (!best_has || dev_tot < best_dev) begin
                best_has <= 1'b1;
                best_dev <= dev_tot;
                for (int i = 0; i < 3; i++) best[i] <= mean[i];
              end
              dev <= '0;
              n   <= 3'd0;
              k   <= 2'd0;
              for (int i = 0; i < 3; i++) begin
                sum[i] <= '0;
                sq[i]  <= '0;
              end
              if (q == 2'd3) begin
                state <= B_OUT;
              end else begin
                q     <= q + 2'd1;
                state <= B_RD;
              end
            end else begin
              dev   <= dev_tot;
              c     <= c + 2'd1;
              state <= B_DM;
            end
          end
        end
        B_OUT: begin
          if (out_ready) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_rd_only_in_read: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> (state == B_RD))
    else $error("store read outside the read phase");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == B_RD))
    else $error("popped job did not start reading");
  a_count: assert property (@(posedge clk) disable iff (rst) n <= 3'd4)
    else $error("quadrant pixel count above four");

endmodule
